// ===== rtl/kdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdc_pkg;

  localparam int NUM_DET = 7;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int DET_IDX_W = 3;
  localparam int FILTER_W = 7;
  localparam int COUNT_W = 8;
  localparam int CODE_W = 4;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(5 / 2);

  localparam logic [CODE_W-1:0] KC_NONE = 4'd0;
  localparam logic [CODE_W-1:0] KC_UP_PRESS = 4'd1;
  localparam logic [CODE_W-1:0] KC_UP_RELEASE = 4'd2;
  localparam logic [CODE_W-1:0] KC_DOWN_PRESS = 4'd3;
  localparam logic [CODE_W-1:0] KC_DOWN_RELEASE = 4'd4;
  localparam logic [CODE_W-1:0] KC_OK_PRESS = 4'd5;
  localparam logic [CODE_W-1:0] KC_OK_RELEASE = 4'd6;
  localparam logic [CODE_W-1:0] KC_MENU_PRESS = 4'd7;
  localparam logic [CODE_W-1:0] KC_MENU_RELEASE = 4'd8;
  localparam logic [CODE_W-1:0] KC_MENU_UP = 4'd9;
  localparam logic [CODE_W-1:0] KC_UP_MENU = 4'd10;
  localparam logic [CODE_W-1:0] KC_MENU_DOWN = 4'd11;
  localparam logic [CODE_W-1:0] KC_DOWN_MENU = 4'd12;
  localparam logic [CODE_W-1:0] KC_MENU_OK = 4'd13;
  localparam logic [CODE_W-1:0] KC_LAST = KC_MENU_OK;

  localparam logic [DET_IDX_W-1:0] DET_UP = 3'd0;
  localparam logic [DET_IDX_W-1:0] DET_DOWN = 3'd1;
  localparam logic [DET_IDX_W-1:0] DET_OK = 3'd2;
  localparam logic [DET_IDX_W-1:0] DET_MENU = 3'd3;
  localparam logic [DET_IDX_W-1:0] DET_MENU_UP = 3'd4;
  localparam logic [DET_IDX_W-1:0] DET_MENU_DOWN = 3'd5;
  localparam logic [DET_IDX_W-1:0] DET_MENU_OK = 3'd6;

  typedef enum logic [1:0] {
    SMP_NONE   = 2'd0,
    SMP_BOTH   = 2'd1,
    SMP_FIRST  = 2'd2,
    SMP_SECOND = 2'd3
  } sample_t;

  typedef enum logic [1:0] {
    DET_RELEASED = 2'd0,
    DET_PRESSED  = 2'd1,
    DET_FIRST    = 2'd2,
    DET_SECOND   = 2'd3
  } det_state_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_FIRST   = 2'd2,
    EV_SECOND  = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_TICK   = 2'd1,
    ST_FINISH = 2'd2
  } kdc_state_t;

  typedef struct packed {
    det_state_t           state;
    logic [COUNT_W-1:0]   count;
  } det_entry_t;

  localparam det_entry_t DET_ENTRY_RESET = '{state: DET_RELEASED, count: COUNT_RESET};

  typedef struct packed {
    logic command;
    logic up_level;
    logic down_level;
    logic ok_level;
    logic menu_level;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              key_valid;
  } out_item_t;

  function automatic sample_t combo_sample(input logic first, input logic second);
    sample_t s;
    if (first && second) begin
      s = SMP_BOTH;
    end else if (first) begin
      s = SMP_FIRST;
    end else if (second) begin
      s = SMP_SECOND;
    end else begin
      s = SMP_NONE;
    end
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] det_code(input logic [DET_IDX_W-1:0] idx,
                                                 input event_kind_t kind);
    logic [CODE_W-1:0] c;
    c = KC_NONE;
    case (idx)
      DET_UP: begin
        if (kind == EV_PRESS) c = KC_UP_PRESS;
        else if (kind == EV_RELEASE) c = KC_UP_RELEASE;
      end
      DET_DOWN: begin
        if (kind == EV_PRESS) c = KC_DOWN_PRESS;
        else if (kind == EV_RELEASE) c = KC_DOWN_RELEASE;
      end
      DET_OK: begin
        if (kind == EV_PRESS) c = KC_OK_PRESS;
        else if (kind == EV_RELEASE) c = KC_OK_RELEASE;
      end
      DET_MENU: begin
        if (kind == EV_PRESS) c = KC_MENU_PRESS;
        else if (kind == EV_RELEASE) c = KC_MENU_RELEASE;
      end
      DET_MENU_UP: begin
        if (kind == EV_FIRST) c = KC_MENU_UP;
        else if (kind == EV_SECOND) c = KC_UP_MENU;
      end
      DET_MENU_DOWN: begin
        if (kind == EV_FIRST) c = KC_MENU_DOWN;
        else if (kind == EV_SECOND) c = KC_DOWN_MENU;
      end
      DET_MENU_OK: begin
        if (kind == EV_FIRST) c = KC_MENU_OK;
      end
      default: c = KC_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kdc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/kdc_det_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdc_det_update
  import kdc_pkg::*;
(
  input  wire logic [DET_IDX_W-1:0] idx,
  input  wire sample_t              sample,
  input  wire logic [FILTER_W-1:0]  filter_time,
  input  wire det_entry_t           cur,
  output det_entry_t                nxt,
  output logic [CODE_W-1:0]         push_code
);

  logic [COUNT_W-1:0] ft;
  logic [COUNT_W-1:0] top;
  logic [COUNT_W-1:0] up_cnt;
  logic [COUNT_W-1:0] dn_cnt;
  logic               up_done;
  logic               dn_done;

  always_comb begin
    ft = {1'b0, filter_time};
    top = {filter_time, 1'b0};
    up_done = (cur.count >= top);
    dn_done = (cur.count == '0);
    if (cur.count < ft) begin
      up_cnt = ft;
    end else if (cur.count < top) begin
      up_cnt = cur.count + COUNT_W'(1);
    end else begin
      up_cnt = cur.count;
    end
    if (cur.count > ft) begin
      dn_cnt = ft;
    end else if (!dn_done) begin
      dn_cnt = cur.count - COUNT_W'(1);
    end else begin
      dn_cnt = cur.count;
    end
  end

  always_comb begin
    nxt = cur;
    push_code = KC_NONE;
    case (sample)
      SMP_NONE: begin
        if (cur.state != DET_RELEASED) begin
          nxt.count = dn_cnt;
          if (dn_done) begin
            nxt.state = DET_RELEASED;
            push_code = det_code(idx, EV_RELEASE);
          end
        end
      end
      SMP_BOTH: begin
        if (cur.state != DET_PRESSED) begin
          nxt.count = up_cnt;
          if (up_done) begin
            nxt.state = DET_PRESSED;
            case (cur.state)
              DET_RELEASED: push_code = det_code(idx, EV_PRESS);
              DET_FIRST:    push_code = det_code(idx, EV_FIRST);
              default:      push_code = det_code(idx, EV_SECOND);
            endcase
          end
        end
      end
      default: begin
        if (cur.state == DET_RELEASED) begin
          nxt.count = up_cnt;
          if (up_done) begin
            nxt.state = det_state_t'(sample);
          end
        end else if (cur.state == DET_PRESSED) begin
          nxt.count = dn_cnt;
          if (dn_done) begin
            nxt.state = det_state_t'(sample);
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/key_debounce_combo_fifo_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounces four keys and queues press, release and menu-combination events in a
// FIFO of FIFO_DEPTH entries. One transaction is in flight at a time. A tick
// (command 0) walks the seven detectors, which live in a single-port-per-side
// state RAM: each is read, updated and written back, one per cycle, with at most
// one FIFO push per cycle; ST_FINISH then loads the result once no earlier result
// is stalled. A read (command 1) reads the event RAM as it is accepted and loads
// the registered read data in ST_FINISH. The next transaction can be accepted in
// the same cycle the result is offered. Every transaction returns one result; a
// tick or an empty read returns code zero with key_valid low. There is no full
// check: a push with FIFO_DEPTH-1 entries queued makes the FIFO read as empty.
module key_debounce_combo_fifo_top
  import kdc_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [FILTER_W-1:0] cfg_wr_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [DET_IDX_W-1:0] STEP_LAST = DET_IDX_W'(NUM_DET);

  kdc_state_t           state_r, state_nxt;
  logic [DET_IDX_W-1:0] step_r, step_nxt;
  in_item_t             lvl_r;
  logic                 hit_r;
  logic [PTR_W-1:0]     rd_ptr_r, wr_ptr_r;
  logic [FILTER_W-1:0]  filter_r;
  logic [NUM_DET-1:0]   det_vld_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 accept;
  logic                 fifo_empty;
  logic                 det_rd_en;
  logic                 proc_en;
  logic                 fifo_rd_en;
  logic                 finish_load;
  logic [DET_IDX_W-1:0] proc_idx;
  logic [$bits(det_entry_t)-1:0] det_rd_bits;
  det_entry_t           det_cur, det_new;
  sample_t              sample;
  logic [CODE_W-1:0]    push_code;
  logic                 push_en;
  logic [CODE_W-1:0]    fifo_rd_data;

  assign fifo_empty = (rd_ptr_r == wr_ptr_r);
  assign accept = in_valid && in_ready;
  assign proc_idx = step_r - DET_IDX_W'(1);
  assign det_cur = det_vld_r[proc_idx] ? det_entry_t'(det_rd_bits) : DET_ENTRY_RESET;
  assign push_en = proc_en && (push_code != KC_NONE);

  always_comb begin
    unique case (proc_idx)
      DET_UP:        sample = sample_t'({1'b0, lvl_r.up_level});
      DET_DOWN:      sample = sample_t'({1'b0, lvl_r.down_level});
      DET_OK:        sample = sample_t'({1'b0, lvl_r.ok_level});
      DET_MENU:      sample = sample_t'({1'b0, lvl_r.menu_level});
      DET_MENU_UP:   sample = combo_sample(lvl_r.menu_level, lvl_r.up_level);
      DET_MENU_DOWN: sample = combo_sample(lvl_r.menu_level, lvl_r.down_level);
      DET_MENU_OK:   sample = combo_sample(lvl_r.menu_level, lvl_r.ok_level);
      default:       sample = SMP_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = in_data.command ? ST_FINISH : ST_TICK;
        end
      end
      ST_TICK: begin
        step_nxt = step_r + DET_IDX_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    det_rd_en = 1'b0;
    proc_en = 1'b0;
    fifo_rd_en = 1'b0;
    finish_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        fifo_rd_en = in_valid && in_data.command && !fifo_empty;
      end
      ST_TICK: begin
        det_rd_en = (step_r != STEP_LAST);
        proc_en = (step_r != '0);
      end
      ST_FINISH: begin
        finish_load = !out_valid_r || out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  kdc_ram #(
    .WIDTH($bits(det_entry_t)),
    .DEPTH(NUM_DET)
  ) u_det_ram (
    .clk    (clk),
    .wr_en  (proc_en),
    .wr_addr(proc_idx),
    .wr_data(det_new),
    .rd_en  (det_rd_en),
    .rd_addr(step_r),
    .rd_data(det_rd_bits)
  );

  kdc_det_update u_det_update (
    .idx        (proc_idx),
    .sample     (sample),
    .filter_time(filter_r),
    .cur        (det_cur),
    .nxt        (det_new),
    .push_code  (push_code)
  );

  kdc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(FIFO_DEPTH)
  ) u_event_ram (
    .clk    (clk),
    .wr_en  (push_en),
    .wr_addr(wr_ptr_r),
    .wr_data(push_code),
    .rd_en  (fifo_rd_en),
    .rd_addr(rd_ptr_r),
    .rd_data(fifo_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      hit_r <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      filter_r <= FILTER_RESET;
      det_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      if (cfg_wr_en) begin
        filter_r <= cfg_wr_data;
      end
      if (accept) begin
        hit_r <= fifo_rd_en;
      end
      if (fifo_rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (proc_en) begin
        det_vld_r[proc_idx] <= 1'b1;
      end
      if (finish_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lvl_r <= in_data;
    end
    if (finish_load) begin
      out_data_r.key_code <= hit_r ? fifo_rd_data : KC_NONE;
      out_data_r.key_valid <= hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/kdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdc_checker
  import kdc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or dropped while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second transaction was taken while one is in flight.");

  a_no_code_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_valid |-> out_data.key_code == KC_NONE)
    else $error("Nonzero key code offered without key_valid.");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_valid |->
      out_data.key_code != KC_NONE && out_data.key_code <= KC_LAST)
    else $error("Popped key code is out of range.");

endmodule

bind key_debounce_combo_fifo_top kdc_checker u_kdc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
